/* sv/u16u8_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [15:0] REPLACE_CP = 16'hFFFD;
	localparam logic [20:0] PLANE1_CP  = 21'h10000;
	localparam int          RUN_BYTES  = 6;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
	} seq_t;

	typedef struct packed {
		logic [RUN_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      name_last;
	} result_t;

	function automatic seq_t enc_point(input logic [20:0] cp);
		seq_t s;
		s.bytes = '0;
		if (cp < 21'h80) begin
			s.bytes[0] = cp[7:0];
			s.len = 3'd1;
		end else if (cp < 21'h800) begin
			s.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
			s.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
			s.len = 3'd2;
		end else if (cp < PLANE1_CP) begin
			s.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
			s.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
			s.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
			s.len = 3'd3;
		end else begin
			s.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
			s.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
			s.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
			s.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
			s.len = 3'd4;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

/* sv/u16u8_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none

module u16u8_encoder (
	input  wire logic [15:0]       unit,
	input  wire logic              last,
	input  wire logic              held_valid,
	input  wire logic [15:0]       held_high,
	output u16u8_pkg::result_t     res,
	output logic                   next_valid,
	output logic [15:0]            next_high
);
	import u16u8_pkg::*;

	logic        is_high;
	logic        is_low;
	logic [20:0] pair_cp;
	logic [15:0] cp_b;
	logic        emit_b;
	logic [2:0]  off;
	seq_t        e_pair;
	seq_t        e_held;
	seq_t        e_b;

	assign is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
	assign is_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);
	assign pair_cp = PLANE1_CP + {1'b0, held_high[9:0], unit[9:0]};
	assign cp_b    = is_low ? REPLACE_CP : unit;
	assign emit_b  = !(is_high && !last);
	assign e_pair  = enc_point(pair_cp);
	assign e_held  = enc_point({5'b00000, held_high});
	assign e_b     = enc_point({5'b00000, cp_b});

	always_comb begin
		res.bytes     = '0;
		res.cnt       = 3'd0;
		res.name_last = last;
		off           = 3'd0;
		next_valid    = 1'b0;
		next_high     = held_high;
		if (held_valid && is_low) begin
			res.bytes[3:0] = e_pair.bytes;
			res.cnt        = e_pair.len;
		end else begin
			if (held_valid) begin
				res.bytes[2:0] = e_held.bytes[2:0];
				off            = 3'd3;
			end
			if (emit_b) begin
				for (int i = 0; i < 3; i++) begin
					if (3'(i) < e_b.len) begin
						res.bytes[off + 3'(i)] = e_b.bytes[i];
					end
				end
				res.cnt = off + e_b.len;
			end else begin
				res.cnt    = off;
				next_valid = 1'b1;
				next_high  = unit;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/u16u8_outbuf.sv */
`timescale 1ns / 1ps
`default_nettype none

module u16u8_outbuf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire u16u8_pkg::result_t res,
	output logic                    free,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              out_byte,
	output logic                    run_last,
	output logic                    name_last
);
	import u16u8_pkg::*;

	logic                      valid_s2;
	logic [RUN_BYTES-1:0][7:0] bytes_s2;
	logic [2:0]                cnt_s2;
	logic                      name_last_s2;
	logic [2:0]                idx_q;
	logic                      at_end;
	logic                      xfer;

	assign at_end    = (idx_q == cnt_s2 - 3'd1);
	assign xfer      = valid_s2 && !out_stall;
	assign free      = !valid_s2 || (xfer && at_end);
	assign out_valid = valid_s2;
	assign out_byte  = bytes_s2[idx_q];
	assign run_last  = at_end;
	assign name_last = at_end && name_last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 3'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= 3'd0;
		end else if (xfer) begin
			if (at_end) begin
				valid_s2 <= 1'b0;
				idx_q    <= 3'd0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2     <= res.bytes;
			cnt_s2       <= res.cnt;
			name_last_s2 <= res.name_last;
		end
	end

endmodule

`default_nettype wire

/* sv/utf16_to_utf8_transcoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  valid      stall      payload
// input    in_valid   in_stall   code_unit[15:0], unit_last
// output   out_valid  out_stall  out_byte[7:0], run_last, name_last
//
// one byte leaves per cycle while out_stall is low; a code unit yields up to 6
// bytes (most units 1 to 3, a held high surrogate none), which the byte-wide
// result buffer sends out one at a time
// the input register takes a new unit while the buffer still drains bytes
// a held high surrogate lives in the surrogate register until the next unit
// reset clears all valid flags and the held surrogate

module utf16_to_utf8_transcoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] code_unit,
	input  wire logic        unit_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             name_last
);
	import u16u8_pkg::*;

	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        last_s1;
	logic        held_valid_q;
	logic [15:0] held_high_q;
	result_t     res;
	logic        next_valid;
	logic [15:0] next_high;
	logic        free;
	logic        consume;
	logic        load;

	u16u8_encoder u_enc (
		.unit       (unit_s1),
		.last       (last_s1),
		.held_valid (held_valid_q),
		.held_high  (held_high_q),
		.res        (res),
		.next_valid (next_valid),
		.next_high  (next_high)
	);

	u16u8_outbuf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.name_last (name_last)
	);

	assign consume  = valid_s1 && ((res.cnt == 3'd0) || free);
	assign load     = consume && (res.cnt != 3'd0);
	assign in_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			held_valid_q <= 1'b0;
			held_high_q  <= 16'h0000;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (consume) begin
				held_valid_q <= next_valid;
				held_high_q  <= next_high;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			unit_s1 <= code_unit;
			last_s1 <= unit_last;
		end
	end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	import u16u8_pkg::*;

	typedef struct {
		logic [15:0] unit;
		logic        last;
	} utf16_unit_t;

	typedef struct {
		byte_t data;
		logic  run_end;
		logic  name_end;
	} utf8_byte_t;

	class utf8_scoreboard;
		utf8_byte_t  pending[$];
		logic [15:0] held_unit;
		bit          holding;
		int          errors;

		function new();
			held_unit = '0;
			holding = 0;
			errors = 0;
		endfunction

		function void encode_point(logic [20:0] cp, ref byte_t seq[$]);
			if (cp < 21'h80) begin
				seq = {seq, cp[7:0]};
			end else if (cp < 21'h800) begin
				seq = {seq, 8'hC0 | 8'(cp >> 6)};
				seq = {seq, 8'h80 | 8'(cp & 21'h3F)};
			end else if (cp < PLANE1_CP) begin
				seq = {seq, 8'hE0 | 8'(cp >> 12)};
				seq = {seq, 8'h80 | 8'((cp >> 6) & 21'h3F)};
				seq = {seq, 8'h80 | 8'(cp & 21'h3F)};
			end else begin
				seq = {seq, 8'hF0 | 8'((cp >> 18) & 21'h07)};
				seq = {seq, 8'h80 | 8'((cp >> 12) & 21'h3F)};
				seq = {seq, 8'h80 | 8'((cp >> 6) & 21'h3F)};
				seq = {seq, 8'h80 | 8'(cp & 21'h3F)};
			end
		endfunction

		// predicts the bytes of one accepted code unit
		function void note_unit(logic [15:0] unit, logic last);
			byte_t       seq[$];
			bit          is_high;
			bit          is_low;
			logic [20:0] cp;
			utf8_byte_t  b;
			is_high = unit >= HIGH_FIRST && unit <= HIGH_LAST;
			is_low = unit >= LOW_FIRST && unit <= LOW_LAST;
			if (holding && is_low) begin
				cp = PLANE1_CP + (21'(held_unit - HIGH_FIRST) << 10) + 21'(unit - LOW_FIRST);
				holding = 0;
				held_unit = '0;
				encode_point(cp, seq);
			end else begin
				if (holding) begin
					encode_point(21'(held_unit), seq);
					holding = 0;
					held_unit = '0;
				end
				if (is_high) begin
					if (last) begin
						encode_point(21'(unit), seq);
					end else begin
						held_unit = unit;
						holding = 1;
					end
				end else if (is_low) begin
					encode_point(21'(REPLACE_CP), seq);
				end else begin
					encode_point(21'(unit), seq);
				end
			end
			foreach (seq[i]) begin
				b.data = seq[i];
				b.run_end = (i == seq.size() - 1);
				b.name_end = (i == seq.size() - 1) && last;
				pending = {pending, b};
			end
		endfunction

		function void check_byte(byte_t data, logic run_end, logic name_end);
			utf8_byte_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected byte, expected none, actual %h run_last %b name_last %b",
					$time, data, run_end, name_end);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (want.data !== data) begin
				$display("%0t: out_byte expected %h actual %h", $time, want.data, data);
				errors++;
			end
			if (want.run_end !== run_end) begin
				$display("%0t: run_last expected %b actual %b", $time, want.run_end, run_end);
				errors++;
			end
			if (want.name_end !== name_end) begin
				$display("%0t: name_last expected %b actual %b", $time, want.name_end, name_end);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] code_unit;
	logic        unit_last;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        name_last;

	utf8_scoreboard sb;
	utf16_unit_t    unit_plan[$];
	bit             quiet;
	bit             long_hold;

	utf16_to_utf8_transcoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.unit_last(unit_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last),
		.name_last(name_last)
	);

	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid === 1'b1 && in_stall === 1'b0)
				sb.note_unit(code_unit, unit_last);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				sb.check_byte(out_byte, run_last, name_last);
		end
	end

	function automatic void add_unit(logic [15:0] unit, logic last);
		utf16_unit_t u;
		u.unit = unit;
		u.last = last;
		unit_plan = {unit_plan, u};
	endfunction

	function automatic logic [15:0] pick_unit();
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom_range(0, 16'h7F));
			2: return 16'($urandom_range(16'h80, 16'h7FF));
			3: return 16'($urandom_range(16'h800, 16'hD7FF));
			4: return 16'($urandom_range(16'hE000, 16'hFFFF));
			5: return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
			6: return 16'($urandom_range(LOW_FIRST, LOW_LAST));
			default: return 16'($urandom);
		endcase
	endfunction

	// one name of random length, mostly well formed, some stray last flags
	function automatic void add_name();
		int len;
		int k;
		logic flag;
		len = $urandom_range(1, 8);
		k = 0;
		while (k < len) begin
			if ($urandom_range(0, 9) < 3 && k + 1 < len) begin
				add_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0);
				add_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), k + 2 == len);
				k += 2;
			end else begin
				flag = (k + 1 == len);
				if ($urandom_range(0, 9) == 0)
					flag = ~flag;
				add_unit(pick_unit(), flag);
				k++;
			end
		end
	endfunction

	task automatic send_units();
		int gap;
		@(negedge clk);
		foreach (unit_plan[i]) begin
			if (i == 120 || i == 350)
				long_hold = 1;
			quiet = (i >= 200 && i < 280);
			gap = quiet ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid = 0;
				repeat (gap) @(negedge clk);
			end
			code_unit = unit_plan[i].unit;
			unit_last = unit_plan[i].last;
			in_valid = 1;
			do @(posedge clk); while (in_stall !== 1'b0);
			@(negedge clk);
		end
		in_valid = 0;
	endtask

	task automatic take_bytes();
		int pause;
		@(negedge clk);
		forever begin
			pause = quiet ? 0 : $urandom_range(0, 6);
			if (long_hold) begin
				pause = 300;
				long_hold = 0;
			end
			if (pause > 0) begin
				out_stall = 1;
				repeat (pause) @(negedge clk);
			end
			out_stall = 0;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		in_valid = 0;
		code_unit = '0;
		unit_last = 0;
		out_stall = 0;
		quiet = 0;
		long_hold = 0;

		// code point boundaries
		add_unit(16'h0000, 1'b0);
		add_unit(16'h007F, 1'b0);
		add_unit(16'h0080, 1'b0);
		add_unit(16'h07FF, 1'b0);
		add_unit(16'h0800, 1'b0);
		add_unit(16'hD7FF, 1'b0);
		add_unit(16'hE000, 1'b0);
		add_unit(16'hFFFF, 1'b0);
		// lowest and highest surrogate pairs
		add_unit(HIGH_FIRST, 1'b0);
		add_unit(LOW_FIRST, 1'b0);
		add_unit(HIGH_LAST, 1'b0);
		add_unit(LOW_LAST, 1'b0);
		// unpaired low
		add_unit(LOW_FIRST, 1'b0);
		// held high followed by a plain unit
		add_unit(16'hD800, 1'b0);
		add_unit(16'h0041, 1'b0);
		// held high replaced by another high, then paired
		add_unit(16'hD801, 1'b0);
		add_unit(16'hDB00, 1'b0);
		add_unit(16'hDC01, 1'b0);
		// held high then a 3-byte unit
		add_unit(16'hD900, 1'b0);
		add_unit(16'hE000, 1'b0);
		// high surrogate ending a name
		add_unit(HIGH_LAST, 1'b1);
		add_unit(16'hD900, 1'b0);
		add_unit(16'hDA00, 1'b1);
		// pair ending a name
		add_unit(16'hD801, 1'b0);
		add_unit(16'hDC02, 1'b1);
		add_unit(16'h0041, 1'b1);

		while (unit_plan.size() < 450)
			add_name();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		fork
			take_bytes();
		join_none
		send_units();

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
